// ===== rtl/csd_pkg.sv =====
// Package with the shared types, codes and constants of the CBOR stream decoder.
package csd_pkg;

  localparam int unsigned LENGTH_WIDTH = 32;

  localparam logic [4:0] INFO_ARG1    = 5'd24;
  localparam logic [4:0] INFO_ARG2    = 5'd25;
  localparam logic [4:0] INFO_ARG4    = 5'd26;
  localparam logic [4:0] INFO_ARG8    = 5'd27;
  localparam logic [4:0] INFO_INDEF   = 5'd31;
  localparam logic [4:0] INFO_FALSE   = 5'd20;
  localparam logic [4:0] INFO_TRUE    = 5'd21;
  localparam logic [4:0] INFO_NULL    = 5'd22;
  localparam logic [4:0] INFO_UNDEF   = 5'd23;

  localparam logic [2:0] MAJOR_UINT   = 3'd0;
  localparam logic [2:0] MAJOR_NEGINT = 3'd1;
  localparam logic [2:0] MAJOR_BYTES  = 3'd2;
  localparam logic [2:0] MAJOR_TEXT   = 3'd3;
  localparam logic [2:0] MAJOR_ARRAY  = 3'd4;
  localparam logic [2:0] MAJOR_MAP    = 3'd5;
  localparam logic [2:0] MAJOR_TAG    = 3'd6;
  localparam logic [2:0] MAJOR_SIMPLE = 3'd7;

  typedef enum logic [3:0] {
    KIND_UINT    = 4'd0,
    KIND_NEGINT  = 4'd1,
    KIND_BYTES   = 4'd2,
    KIND_TEXT    = 4'd3,
    KIND_ARRAY   = 4'd4,
    KIND_MAP     = 4'd5,
    KIND_TAG     = 4'd6,
    KIND_FALSE   = 4'd7,
    KIND_TRUE    = 4'd8,
    KIND_NULL    = 4'd9,
    KIND_UNDEF   = 4'd10,
    KIND_F32     = 4'd11,
    KIND_F64     = 4'd12,
    KIND_BREAK   = 4'd13,
    KIND_PAYLOAD = 4'd14,
    KIND_ERROR   = 4'd15
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_RESERVED    = 3'd1,
    ERR_INDEF_STR   = 3'd2,
    ERR_SIMPLE      = 3'd3,
    ERR_TRUNCATED   = 3'd4,
    ERR_WIDE        = 3'd5
  } err_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_ARG     = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_e;

  typedef struct packed {
    phase_e                  phase;
    logic [2:0]              major;
    logic [4:0]              info;
    logic [3:0]              left;
    logic [63:0]             acc;
    logic [LENGTH_WIDTH-1:0] payload_left;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    phase:        PH_IDLE,
    major:        '0,
    info:         '0,
    left:         '0,
    acc:          '0,
    payload_left: '0
  };

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
    logic [3:0]  arg_bytes;
    logic        indefinite;
    logic        payload_last;
    err_e        error_code;
  } result_t;

  localparam result_t RESULT_NONE = '{
    kind:         KIND_UINT,
    value:        '0,
    arg_bytes:    '0,
    indefinite:   1'b0,
    payload_last: 1'b0,
    error_code:   ERR_NONE
  };

endpackage

// ===== rtl/csd_in_if.sv =====
// Input channel of the CBOR stream decoder: one encoded byte per transaction.
interface csd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_buffer;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output start_of_buffer,
                  output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input start_of_buffer,
                input end_of_buffer, output ready);
endinterface

// ===== rtl/csd_out_if.sv =====
// Output channel of the CBOR stream decoder: one decoded item per transaction.
interface csd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  item_kind;
  logic [63:0] item_value;
  logic [3:0]  argument_bytes;
  logic        indefinite;
  logic        payload_last;
  logic [2:0]  error_code;

  modport source (output valid, output item_kind, output item_value,
                  output argument_bytes, output indefinite, output payload_last,
                  output error_code, input ready);
  modport sink (input valid, input item_kind, input item_value,
                input argument_bytes, input indefinite, input payload_last,
                input error_code, output ready);
endinterface

// ===== rtl/csd_step.sv =====
// Combinational next-state and result logic of the decoder for one input byte.
module csd_step
  import csd_pkg::*;
(
  input  state_t      state_i,
  input  logic [7:0]  byte_i,
  input  logic        sob_i,
  input  logic        eob_i,
  input  logic        byte_order_i,
  output state_t      state_o,
  output logic        res_valid_o,
  output result_t     res_o
);

  typedef struct packed {
    result_t                 res;
    logic                    to_payload;
    logic [LENGTH_WIDTH-1:0] len;
  } finish_t;

  function automatic finish_t finish_head(logic [2:0] major, logic [4:0] info,
                                          logic [63:0] v, logic [3:0] nb);
    finish_t f;
    logic    wide;
    f            = '{res: RESULT_NONE, to_payload: 1'b0, len: '0};
    wide         = (v >> LENGTH_WIDTH) != 64'd0;
    f.len        = v[LENGTH_WIDTH-1:0];
    f.res.value  = v;
    f.res.arg_bytes = nb;
    unique case (major)
      MAJOR_UINT, MAJOR_NEGINT, MAJOR_TAG: begin
        f.res.kind = kind_e'({1'b0, major});
      end
      MAJOR_BYTES, MAJOR_TEXT, MAJOR_ARRAY, MAJOR_MAP: begin
        if (wide) begin
          f.res.kind       = KIND_ERROR;
          f.res.error_code = ERR_WIDE;
        end else begin
          f.res.kind = kind_e'({1'b0, major});
          f.to_payload = (major == MAJOR_BYTES || major == MAJOR_TEXT) && (v != 64'd0);
        end
      end
      default: begin
        if (info == INFO_FALSE || info == INFO_TRUE || info == INFO_NULL ||
            info == INFO_UNDEF) begin
          f.res.kind      = kind_e'(4'(KIND_FALSE) + {2'b00, info[1:0]});
          f.res.value     = '0;
          f.res.arg_bytes = '0;
        end else if (info == INFO_ARG4) begin
          f.res.kind = KIND_F32;
        end else if (info == INFO_ARG8) begin
          f.res.kind = KIND_F64;
        end else begin
          f.res.kind       = KIND_ERROR;
          f.res.error_code = ERR_SIMPLE;
        end
      end
    endcase
    return f;
  endfunction

  state_t                  s;
  finish_t                 fin;
  logic [2:0]              major;
  logic [4:0]              info;
  logic [3:0]              total;
  logic [2:0]              idx;
  logic [63:0]             acc_new;
  logic [3:0]              left_new;
  logic [LENGTH_WIDTH-1:0] pl_new;

  assign major    = byte_i[7:5];
  assign info     = byte_i[4:0];
  assign total    = 4'b0001 << state_i.info[1:0];

  always_comb begin
    s           = sob_i ? STATE_CLEAR : state_i;
    state_o     = s;
    res_valid_o = 1'b0;
    res_o       = RESULT_NONE;
    fin         = '{res: RESULT_NONE, to_payload: 1'b0, len: '0};
    idx         = 3'(total - s.left);
    acc_new     = byte_order_i ? (s.acc | (64'(byte_i) << {idx, 3'b000}))
                               : {s.acc[55:0], byte_i};
    left_new    = s.left - 4'd1;
    pl_new      = s.payload_left - LENGTH_WIDTH'(1);

    unique case (s.phase)
      PH_IDLE: begin
        if (info < INFO_ARG1) begin
          fin         = finish_head(major, info, 64'(info), 4'd0);
          res_o       = fin.res;
          res_valid_o = 1'b1;
          if (fin.to_payload) begin
            state_o.phase        = PH_PAYLOAD;
            state_o.payload_left = fin.len;
          end
        end else if (info <= INFO_ARG8) begin
          state_o.phase = PH_ARG;
          state_o.major = major;
          state_o.info  = info;
          state_o.left  = 4'b0001 << info[1:0];
          state_o.acc   = '0;
        end else begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_ERROR;
          res_o.value = 64'(byte_i);
          if (info != INFO_INDEF) begin
            res_o.error_code = ERR_RESERVED;
          end else if (major == MAJOR_BYTES || major == MAJOR_TEXT) begin
            res_o.error_code = ERR_INDEF_STR;
          end else if (major == MAJOR_ARRAY || major == MAJOR_MAP) begin
            res_o.kind       = kind_e'({1'b0, major});
            res_o.value      = '0;
            res_o.indefinite = 1'b1;
          end else if (major == MAJOR_SIMPLE) begin
            res_o.kind  = KIND_BREAK;
            res_o.value = '0;
          end else begin
            res_o.error_code = ERR_RESERVED;
          end
        end
      end
      PH_ARG: begin
        state_o.acc  = acc_new;
        state_o.left = left_new;
        if (left_new == 4'd0) begin
          fin           = finish_head(s.major, s.info, acc_new, total);
          res_o         = fin.res;
          res_valid_o   = 1'b1;
          state_o.phase = PH_IDLE;
          if (fin.to_payload) begin
            state_o.phase        = PH_PAYLOAD;
            state_o.payload_left = fin.len;
          end
        end
      end
      PH_PAYLOAD: begin
        state_o.payload_left = pl_new;
        res_valid_o          = 1'b1;
        res_o.kind           = KIND_PAYLOAD;
        res_o.value          = 64'(byte_i);
        res_o.payload_last   = (pl_new == '0);
        if (pl_new == '0) begin
          state_o.phase = PH_IDLE;
        end
      end
      default: begin
        state_o = STATE_CLEAR;
      end
    endcase

    if (eob_i && state_o.phase != PH_IDLE) begin
      res_o            = RESULT_NONE;
      res_o.kind       = KIND_ERROR;
      res_o.error_code = ERR_TRUNCATED;
      res_o.value      = (state_o.phase == PH_ARG) ? 64'(state_o.left)
                                                   : 64'(state_o.payload_left);
      res_valid_o      = 1'b1;
      state_o          = STATE_CLEAR;
    end
  end

endmodule

// ===== rtl/cbor_stream_decoder_unit.sv =====
// Top level of the CBOR stream decoder: parse state, output register and handshakes.
//
//   channel  direction  transaction
//   in_i     sink       one encoded byte with buffer start and end marks
//   out_o    source     one decoded item, payload byte or error
//   cfg      write      byte order of multi-byte arguments
//
// Each byte is decoded in the cycle it is accepted and its result, if any, is
// held in the output register, so one byte per cycle is taken when the sink
// keeps up. A byte is accepted while the output register is empty or drains in
// the same cycle. Reset clears the parse state and selects big-endian order.
module cbor_stream_decoder_unit
  import csd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  csd_in_if.sink    in_i,
  csd_out_if.source out_o
);

  state_t  state_q, state_d;
  logic    byte_order_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  result_t res;
  logic    res_valid;
  logic    accept;

  csd_step u_step (
    .state_i      (state_q),
    .byte_i       (in_i.data_byte),
    .sob_i        (in_i.start_of_buffer),
    .eob_i        (in_i.end_of_buffer),
    .byte_order_i (byte_order_q),
    .state_o      (state_d),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign out_valid_d = accept ? res_valid : (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= STATE_CLEAR;
      byte_order_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        byte_order_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.item_kind      = out_res_q.kind;
  assign out_o.item_value     = out_res_q.value;
  assign out_o.argument_bytes = out_res_q.arg_bytes;
  assign out_o.indefinite     = out_res_q.indefinite;
  assign out_o.payload_last   = out_res_q.payload_last;
  assign out_o.error_code     = out_res_q.error_code;

endmodule

// ===== tb/tb_cbor_stream_decoder_unit.sv =====
// Self-checking testbench for the CBOR stream decoder with directed rows and random streams.
module tb_cbor_stream_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import csd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PRESSURE_AT    = 700;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_BYTES    = 480;

  typedef struct {
    logic [7:0] b;
    logic       sob;
    logic       eob;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;

  csd_in_if  byte_ch ();
  csd_out_if item_ch ();

  cbor_stream_decoder_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (byte_ch),
    .out_o      (item_ch)
  );

  always #5 clk_i = ~clk_i;

  phase_e      dec_phase;
  logic [2:0]  dec_major;
  logic [4:0]  dec_info;
  logic [3:0]  dec_left;
  logic [63:0] dec_acc;
  logic [63:0] dec_payload_left;
  logic        order_le;

  result_t   expected_items[$];
  stim_row_t directed_rows[$];
  int        fail_count  = 0;
  int        items_seen  = 0;
  int        bytes_sent  = 0;
  int        stall_cycles = 0;
  bit        gaps_on     = 1'b1;
  bit        need_sob    = 1'b1;

  function automatic void clear_decoder();
    dec_phase        = PH_IDLE;
    dec_major        = '0;
    dec_info         = '0;
    dec_left         = '0;
    dec_acc          = '0;
    dec_payload_left = '0;
  endfunction

  function automatic result_t make_result(input kind_e k, input logic [63:0] v,
                                          input logic [3:0] nb, input logic indef,
                                          input logic last, input err_e e);
    result_t r;
    r.kind         = k;
    r.value        = v;
    r.arg_bytes    = nb;
    r.indefinite   = indef;
    r.payload_last = last;
    r.error_code   = e;
    return r;
  endfunction

  function automatic result_t close_head(input logic [2:0] major, input logic [4:0] info,
                                         input logic [63:0] v, input logic [3:0] nb);
    logic [63:0] len_max;
    len_max   = {64{1'b1}} >> (64 - LENGTH_WIDTH);
    dec_phase = PH_IDLE;
    case (major)
      MAJOR_UINT, MAJOR_NEGINT, MAJOR_TAG: begin
        return make_result(kind_e'({1'b0, major}), v, nb, 1'b0, 1'b0, ERR_NONE);
      end
      MAJOR_BYTES, MAJOR_TEXT, MAJOR_ARRAY, MAJOR_MAP: begin
        if (v > len_max) return make_result(KIND_ERROR, v, nb, 1'b0, 1'b0, ERR_WIDE);
        if ((major == MAJOR_BYTES || major == MAJOR_TEXT) && v != 0) begin
          dec_payload_left = v;
          dec_phase        = PH_PAYLOAD;
        end
        return make_result(kind_e'({1'b0, major}), v, nb, 1'b0, 1'b0, ERR_NONE);
      end
      default: begin
        if (info >= INFO_FALSE && info <= INFO_UNDEF) begin
          return make_result(kind_e'(KIND_FALSE + (info - INFO_FALSE)), '0, '0, 1'b0, 1'b0,
                             ERR_NONE);
        end
        if (info == INFO_ARG4) return make_result(KIND_F32, v, nb, 1'b0, 1'b0, ERR_NONE);
        if (info == INFO_ARG8) return make_result(KIND_F64, v, nb, 1'b0, 1'b0, ERR_NONE);
        return make_result(KIND_ERROR, v, nb, 1'b0, 1'b0, ERR_SIMPLE);
      end
    endcase
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic sob, input logic eob,
                                     output result_t res);
    logic [2:0]  major;
    logic [4:0]  info;
    logic [3:0]  total;
    logic [63:0] owed;
    int          idx;
    bit          has;
    major = b[7:5];
    info  = b[4:0];
    has   = 1'b0;
    res   = RESULT_NONE;
    if (sob) clear_decoder();
    case (dec_phase)
      PH_IDLE: begin
        has = 1'b1;
        if (info < INFO_ARG1) begin
          res = close_head(major, info, {59'd0, info}, 4'd0);
        end else if (info <= INFO_ARG8) begin
          has       = 1'b0;
          dec_major = major;
          dec_info  = info;
          dec_left  = 4'd1 << (info - INFO_ARG1);
          dec_acc   = '0;
          dec_phase = PH_ARG;
        end else if (info != INFO_INDEF) begin
          res = make_result(KIND_ERROR, {56'd0, b}, '0, 1'b0, 1'b0, ERR_RESERVED);
        end else if (major == MAJOR_BYTES || major == MAJOR_TEXT) begin
          res = make_result(KIND_ERROR, {56'd0, b}, '0, 1'b0, 1'b0, ERR_INDEF_STR);
        end else if (major == MAJOR_ARRAY || major == MAJOR_MAP) begin
          res = make_result(kind_e'({1'b0, major}), '0, '0, 1'b1, 1'b0, ERR_NONE);
        end else if (major == MAJOR_SIMPLE) begin
          res = make_result(KIND_BREAK, '0, '0, 1'b0, 1'b0, ERR_NONE);
        end else begin
          res = make_result(KIND_ERROR, {56'd0, b}, '0, 1'b0, 1'b0, ERR_RESERVED);
        end
      end
      PH_ARG: begin
        total = 4'd1 << (dec_info - INFO_ARG1);
        idx   = total - dec_left;
        if (order_le) dec_acc = dec_acc | ({56'd0, b} << (8 * idx));
        else dec_acc = {dec_acc[55:0], b};
        dec_left = dec_left - 4'd1;
        if (dec_left == 0) begin
          has = 1'b1;
          res = close_head(dec_major, dec_info, dec_acc, total);
        end
      end
      default: begin
        dec_payload_left = dec_payload_left - 64'd1;
        has = 1'b1;
        res = make_result(KIND_PAYLOAD, {56'd0, b}, '0, 1'b0, dec_payload_left == 0, ERR_NONE);
        if (dec_payload_left == 0) dec_phase = PH_IDLE;
      end
    endcase
    if (eob && dec_phase != PH_IDLE) begin
      owed = (dec_phase == PH_ARG) ? {60'd0, dec_left} : dec_payload_left;
      res  = make_result(KIND_ERROR, owed, '0, 1'b0, 1'b0, ERR_TRUNCATED);
      has  = 1'b1;
      clear_decoder();
    end
    return has;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic sob, input logic eob,
                                  input bit typed, input result_t want);
    stim_row_t row;
    row.b     = b;
    row.sob   = sob;
    row.eob   = eob;
    row.typed = typed;
    row.want  = want;
    directed_rows = {directed_rows, row};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic sob, input logic eob,
                           input bit typed, input result_t want);
    int unsigned gap;
    result_t     res;
    bit          has;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid           <= 1'b1;
    byte_ch.data_byte       <= b;
    byte_ch.start_of_buffer <= sob;
    byte_ch.end_of_buffer   <= eob;
    do @(posedge clk_i); while (!byte_ch.ready);
    has = decode_byte(b, sob, eob, res);
    if (typed) expected_items = {expected_items, want};
    else if (has) expected_items = {expected_items, res};
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic emit_object();
    logic [7:0]  enc[$];
    logic [63:0] arg;
    logic [2:0]  major;
    logic [4:0]  info;
    int          nbytes, payload, last, eob_at, roll, i;
    bit          noise, restart, wide;
    roll    = $urandom_range(0, 99);
    noise   = (roll < 8);
    restart = 1'b0;
    payload = 0;
    eob_at  = -1;
    if (noise) begin
      repeat ($urandom_range(1, 3)) enc = {enc, 8'($urandom_range(0, 255))};
    end else begin
      major = $urandom_range(0, 7);
      roll  = $urandom_range(0, 9);
      if (roll < 4) info = $urandom_range(0, 23);
      else if (roll < 9) info = $urandom_range(24, 27);
      else info = $urandom_range(28, 31);
      enc = {enc, {major, info}};
      if (info < INFO_ARG1) begin
        payload = info;
      end else if (info <= INFO_ARG8) begin
        nbytes = 1 << (info - INFO_ARG1);
        arg    = {$urandom, $urandom};
        roll   = $urandom_range(0, 9);
        if (roll == 0) arg = '0;
        else if (roll == 1) arg = '1;
        if (nbytes < 8) arg = arg & ((64'd1 << (8 * nbytes)) - 64'd1);
        if (major == MAJOR_BYTES || major == MAJOR_TEXT) begin
          wide = (nbytes == 8) && ($urandom_range(0, 3) == 0);
          if (wide) arg = arg | (64'd1 << LENGTH_WIDTH);
          else arg = $urandom_range(0, 8);
          payload = wide ? 0 : int'(arg[31:0]);
        end
        for (i = 0; i < nbytes; i++) begin
          enc = {enc, (order_le ? arg[8 * i +: 8] : arg[8 * (nbytes - 1 - i) +: 8])};
        end
      end
      if (major == MAJOR_BYTES || major == MAJOR_TEXT) begin
        repeat (payload) enc = {enc, 8'($urandom_range(0, 255))};
      end
    end
    last = enc.size() - 1;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      eob_at = last;
    end else if (roll < 18 && last > 0) begin
      last   = $urandom_range(0, last - 1);
      eob_at = last;
    end else if (roll < 24 && last > 0) begin
      last    = $urandom_range(0, last - 1);
      restart = 1'b1;
    end
    for (i = 0; i <= last; i++) begin
      send_byte(enc[i],
                (i == 0 && (need_sob || $urandom_range(0, 9) == 0)) ||
                  (noise && $urandom_range(0, 3) == 0),
                (i == eob_at) || (noise && $urandom_range(0, 3) == 0),
                1'b0, RESULT_NONE);
    end
    need_sob = noise || restart;
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_order(input logic le);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= le;
    order_le     = le;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (item_ch.valid && item_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : drain
    int unsigned hold;
    result_t     got;
    result_t     want;
    item_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = gaps_on ? $urandom_range(0, 3) : 0;
      if (items_seen == PRESSURE_AT) hold = HOLD_CYCLES;
      if (hold != 0) begin
        item_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      item_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!item_ch.valid);
      items_seen++;
      got.kind         = kind_e'(item_ch.item_kind);
      got.value        = item_ch.item_value;
      got.arg_bytes    = item_ch.argument_bytes;
      got.indefinite   = item_ch.indefinite;
      got.payload_last = item_ch.payload_last;
      got.error_code   = err_e'(item_ch.error_code);
      if (expected_items.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected transaction: kind %0d value %h", got.kind, got.value);
        end
      end else begin
        want = expected_items.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch at item %0d", items_seen);
            $display("  expected kind %0d value %h bytes %0d indef %b last %b err %0d",
                     want.kind, want.value, want.arg_bytes, want.indefinite,
                     want.payload_last, want.error_code);
            $display("  actual   kind %0d value %h bytes %0d indef %b last %b err %0d",
                     got.kind, got.value, got.arg_bytes, got.indefinite, got.payload_last,
                     got.error_code);
          end
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin
    byte_ch.valid           = 1'b0;
    byte_ch.data_byte       = '0;
    byte_ch.start_of_buffer = 1'b0;
    byte_ch.end_of_buffer   = 1'b0;
    order_le                = 1'b0;
    clear_decoder();

    add_row(8'h00, 1'b1, 1'b0, 1'b1, make_result(KIND_UINT, 64'd0, 4'd0, 1'b0, 1'b0, ERR_NONE));
    add_row(8'h37, 1'b0, 1'b0, 1'b1, make_result(KIND_NEGINT, 64'd23, 4'd0, 1'b0, 1'b0, ERR_NONE));
    add_row(8'hC6, 1'b0, 1'b0, 1'b1, make_result(KIND_TAG, 64'd6, 4'd0, 1'b0, 1'b0, ERR_NONE));
    add_row(8'h9F, 1'b0, 1'b0, 1'b1, make_result(KIND_ARRAY, 64'd0, 4'd0, 1'b1, 1'b0, ERR_NONE));
    add_row(8'hBF, 1'b0, 1'b0, 1'b1, make_result(KIND_MAP, 64'd0, 4'd0, 1'b1, 1'b0, ERR_NONE));
    add_row(8'hFF, 1'b0, 1'b0, 1'b1, make_result(KIND_BREAK, 64'd0, 4'd0, 1'b0, 1'b0, ERR_NONE));
    add_row(8'hF4, 1'b0, 1'b0, 1'b1, make_result(KIND_FALSE, 64'd0, 4'd0, 1'b0, 1'b0, ERR_NONE));
    add_row(8'hF5, 1'b0, 1'b0, 1'b1, make_result(KIND_TRUE, 64'd0, 4'd0, 1'b0, 1'b0, ERR_NONE));
    add_row(8'hF6, 1'b0, 1'b0, 1'b1, make_result(KIND_NULL, 64'd0, 4'd0, 1'b0, 1'b0, ERR_NONE));
    add_row(8'hF7, 1'b0, 1'b0, 1'b1, make_result(KIND_UNDEF, 64'd0, 4'd0, 1'b0, 1'b0, ERR_NONE));
    add_row(8'hE0, 1'b0, 1'b0, 1'b1,
            make_result(KIND_ERROR, 64'd0, 4'd0, 1'b0, 1'b0, ERR_SIMPLE));
    add_row(8'h1C, 1'b0, 1'b0, 1'b1,
            make_result(KIND_ERROR, 64'h1C, 4'd0, 1'b0, 1'b0, ERR_RESERVED));
    add_row(8'h1F, 1'b0, 1'b0, 1'b1,
            make_result(KIND_ERROR, 64'h1F, 4'd0, 1'b0, 1'b0, ERR_RESERVED));
    add_row(8'h7F, 1'b0, 1'b0, 1'b1,
            make_result(KIND_ERROR, 64'h7F, 4'd0, 1'b0, 1'b0, ERR_INDEF_STR));
    add_row(8'h40, 1'b0, 1'b0, 1'b1, make_result(KIND_BYTES, 64'd0, 4'd0, 1'b0, 1'b0, ERR_NONE));
    add_row(8'h61, 1'b0, 1'b0, 1'b1, make_result(KIND_TEXT, 64'd1, 4'd0, 1'b0, 1'b0, ERR_NONE));
    add_row(8'hFF, 1'b0, 1'b0, 1'b1,
            make_result(KIND_PAYLOAD, 64'hFF, 4'd0, 1'b0, 1'b1, ERR_NONE));
    add_row(8'h9B, 1'b0, 1'b0, 1'b0, RESULT_NONE);
    repeat (7) add_row(8'hFF, 1'b0, 1'b0, 1'b0, RESULT_NONE);
    add_row(8'hFF, 1'b0, 1'b0, 1'b1,
            make_result(KIND_ERROR, {64{1'b1}}, 4'd8, 1'b0, 1'b0, ERR_WIDE));
    add_row(8'h19, 1'b0, 1'b0, 1'b0, RESULT_NONE);
    add_row(8'h12, 1'b0, 1'b1, 1'b1,
            make_result(KIND_ERROR, 64'd1, 4'd0, 1'b0, 1'b0, ERR_TRUNCATED));
    add_row(8'h18, 1'b0, 1'b0, 1'b0, RESULT_NONE);
    add_row(8'h00, 1'b1, 1'b0, 1'b1, make_result(KIND_UINT, 64'd0, 4'd0, 1'b0, 1'b0, ERR_NONE));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      send_byte(directed_rows[r].b, directed_rows[r].sob, directed_rows[r].eob,
                directed_rows[r].typed, directed_rows[r].want);
    end

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_order(p % 2 == 0);
      gaps_on    = (p != 1);
      need_sob   = 1'b1;
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) emit_object();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    fail_count += expected_items.size();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/csd_pkg.sv
rtl/csd_in_if.sv
rtl/csd_out_if.sv
rtl/csd_step.sv
rtl/cbor_stream_decoder_unit.sv
tb/tb_cbor_stream_decoder_unit.sv
